>>> src/port_scan_window_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the port scan window detector
// Shorthand for clocked implication checks with a reset disable.
// ----------------------------------------------------------------------------
`ifndef PORT_SCAN_WINDOW_DETECTOR_UNIT_ASSERT_SVH
`define PORT_SCAN_WINDOW_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PSWD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port scan detector check failed");

// Next-cycle implication.
`define PSWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port scan detector check failed");

`endif

>>> src/pswd_pkg.sv
// ----------------------------------------------------------------------------
// Port scan window detector package
// Sizes, field codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pswd_pkg;

  localparam int FLOW_SLOTS   = 16;
  localparam int WINDOW_DEPTH = 64;

  localparam int SIDX_W    = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int POS_W     = $clog2(WINDOW_DEPTH);
  localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int MEM_DEPTH = FLOW_SLOTS * WINDOW_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int TS_W   = 48;
  localparam int PORT_W = 16;
  localparam int WORD_W = TS_W + PORT_W;

  localparam int IN_TDATA_W  = 128;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] DIR_IN     = 2'd1;
  localparam logic [1:0] DIR_OUT    = 2'd2;
  localparam logic [1:0] PROTO_TCP  = 2'd1;
  localparam logic [1:0] PROTO_UDP  = 2'd2;
  localparam int         SYN_BIT    = 1;
  localparam int         ACK_BIT    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TCP_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UDP_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIM = 3'd4;

  localparam logic [31:0] RST_WINDOW    = 32'd15000;
  localparam logic [31:0] RST_COOLDOWN  = 32'd30000;
  localparam logic [6:0]  RST_TCP_THR   = 7'd18;
  localparam logic [6:0]  RST_UDP_THR   = 7'd24;
  localparam logic [15:0] RST_PROBE_LIM = 16'd96;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_EXP_CHK,
    ST_APPEND,
    ST_SCAN,
    ST_DECIDE,
    ST_RESULT
  } state_t;

  // Ring position plus offset, both below the depth.
  function automatic logic [POS_W-1:0] pos_wrap(input logic [POS_W:0] sum);
    logic [POS_W:0] res;
    res = (sum >= (POS_W+1)'(WINDOW_DEPTH)) ? sum - (POS_W+1)'(WINDOW_DEPTH) : sum;
    return res[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] pos);
    return pos_wrap({1'b0, pos} + (POS_W+1)'(1));
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [SIDX_W-1:0] slot,
                                                  input logic [POS_W-1:0]  pos);
    return ADDR_W'(32'(slot) * WINDOW_DEPTH + 32'(pos));
  endfunction

endpackage

`default_nettype wire

>>> src/port_scan_window_detector_unit.sv
// ----------------------------------------------------------------------------
// Port scan window detector
// Per-flow sliding window of probe events with distinct port count alerts.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one packet descriptor per transaction; in_tready is high only
//            while the sequencer is idle, so one packet is in work at a time.
//   out_*  : exactly one result per packet, held in an output register.
//   cfg_*  : register writes, taken at any edge with cfg_we high; write only
//            while no packet is in work.
// Sequence: an ignored packet goes from idle straight to the result state.
//   A probe first tests the front event of its ring for expiry, dropping
//   each expired event, then appends the new event, then visits every event
//   left in the ring (at most 64) for the distinct count, then decides and
//   loads the result; each expiry test and each event visited needs one
//   read of the event memory.
// Flow: the next packet is taken the cycle after the result is loaded,
//   even if the receiver has not yet taken it. When the receiver stalls,
//   the result holds and a finished second packet waits in the result
//   state, with in_tready low.
// Reset (synchronous, active low) empties every ring, clears the alert
//   history and restores the register defaults; the event memory itself is
//   not cleared, since only live ring entries are ever read.
`default_nettype none

module port_scan_window_detector_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // flow_slot, timestamp_ms, local_port, remote_port, tcp_flags,
  // payload_size, total_size (zero padded to 128 bits)
  input  wire logic [pswd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // direction, protocol, flags_valid
  input  wire logic [pswd_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  // alert, distinct_ports, window_overflow (zero padded to 16 bits)
  output      logic [pswd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // rule_udp
  output      logic                            out_tuser,
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_we,
  input  wire logic [pswd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pswd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pswd_pkg::*;

  // Unpack the incoming descriptor.
  logic [3:0]        in_slot;
  logic [TS_W-1:0]   in_ts;
  logic [1:0]        in_dir;
  logic [1:0]        in_proto;
  logic [PORT_W-1:0] in_lport;
  logic [PORT_W-1:0] in_rport;
  logic              in_fvalid;
  logic [7:0]        in_flags;
  logic [15:0]       in_payload;
  logic [15:0]       in_total;

  assign in_slot    = in_tdata[3:0];
  assign in_ts      = in_tdata[51:4];
  assign in_lport   = in_tdata[67:52];
  assign in_rport   = in_tdata[83:68];
  assign in_flags   = in_tdata[91:84];
  assign in_payload = in_tdata[107:92];
  assign in_total   = in_tdata[123:108];
  assign in_dir     = in_tuser[1:0];
  assign in_proto   = in_tuser[3:2];
  assign in_fvalid  = in_tuser[4];

  // Configuration registers.
  logic [31:0] window_r;
  logic [31:0] cooldown_r;
  logic [6:0]  tcp_thr_r;
  logic [6:0]  udp_thr_r;
  logic [15:0] probe_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= RST_WINDOW;
      cooldown_r  <= RST_COOLDOWN;
      tcp_thr_r   <= RST_TCP_THR;
      udp_thr_r   <= RST_UDP_THR;
      probe_lim_r <= RST_PROBE_LIM;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW:    window_r    <= cfg_wdata;
        CFG_COOLDOWN:  cooldown_r  <= cfg_wdata;
        CFG_TCP_THR:   tcp_thr_r   <= cfg_wdata[6:0];
        CFG_UDP_THR:   udp_thr_r   <= cfg_wdata[6:0];
        CFG_PROBE_LIM: probe_lim_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Packet classification on the incoming transaction.
  logic              dir_ok;
  logic              tcp_probe;
  logic              proto_ok;
  logic              slot_ok;
  logic [PORT_W-1:0] port_sel;
  logic              pkt_ignore;
  logic [SIDX_W-1:0] in_sidx;

  always_comb begin
    dir_ok    = (in_dir == DIR_IN) || (in_dir == DIR_OUT);
    tcp_probe = in_fvalid ? (in_flags[SYN_BIT] && !in_flags[ACK_BIT])
                          : ((in_payload == 16'd0) && (in_total <= probe_lim_r));
    proto_ok  = ((in_proto == PROTO_TCP) && tcp_probe) || (in_proto == PROTO_UDP);
    slot_ok   = 32'(in_slot) < FLOW_SLOTS;
    port_sel  = (in_dir == DIR_IN) ? in_lport : in_rport;
    pkt_ignore = (in_ts == '0) || !dir_ok || !proto_ok || (port_sel == '0) || !slot_ok;
    in_sidx   = SIDX_W'(in_slot);
  end

  // Per-slot ring pointers and alert history, cleared by reset.
  logic [POS_W-1:0] head_a_r [FLOW_SLOTS];
  logic [CNT_W-1:0] cnt_a_r  [FLOW_SLOTS];
  logic [TS_W-1:0]  last_a_r [FLOW_SLOTS];

  // Event memory: {time, port} per ring position of each slot.
  logic [WORD_W-1:0] event_mem [MEM_DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  // Sequencer state and working registers.
  state_t            state_r, state_nxt;
  logic [SIDX_W-1:0] sidx_r, sidx_nxt;
  logic [TS_W-1:0]   now_r, now_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  logic              udp_r, udp_nxt;
  logic [POS_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  ir_r, ir_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [PORT_W-1:0] cam_r [WINDOW_DEPTH];
  logic              cam_we;

  // Result staging and output register.
  logic              res_alert_r, res_alert_nxt;
  logic              res_udp_r, res_udp_nxt;
  logic [6:0]        res_dist_r, res_dist_nxt;
  logic              res_ovf_r, res_ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_alert_r, out_udp_r, out_ovf_r;
  logic [6:0]        out_dist_r;
  logic              out_load;

  logic              slot_we;
  logic              last_we;

  // Working values.
  logic [TS_W-1:0]   rd_time;
  logic [PORT_W-1:0] rd_port;
  logic              expired;
  logic              ring_full;
  logic [POS_W-1:0]  app_head;
  logic [CNT_W-1:0]  app_cnt;
  logic              cam_hit;
  logic [6:0]        thr;
  logic [TS_W-1:0]   last_t;
  logic              cooling;
  logic              alert_now;

  assign rd_time = rd_data_r[WORD_W-1:PORT_W];
  assign rd_port = rd_data_r[PORT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    sidx_nxt      = sidx_r;
    now_nxt       = now_r;
    port_nxt      = port_r;
    udp_nxt       = udp_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    ir_nxt        = ir_r;
    pend_nxt      = pend_r;
    k_nxt         = k_r;
    res_alert_nxt = res_alert_r;
    res_udp_nxt   = res_udp_r;
    res_dist_nxt  = res_dist_r;
    res_ovf_nxt   = res_ovf_r;
    rd_en         = 1'b0;
    rd_addr       = mem_addr(sidx_r, head_r);
    wr_en         = 1'b0;
    cam_we        = 1'b0;
    slot_we       = 1'b0;
    last_we       = 1'b0;
    out_load      = 1'b0;
    in_tready     = 1'b0;

    // Expiry test on the front event just read.
    expired = (now_r > rd_time) && ((now_r - rd_time) > TS_W'(window_r));

    // Drop the oldest event when the ring is still full after expiry.
    ring_full = 32'(cnt_r) >= WINDOW_DEPTH;
    app_head  = ring_full ? pos_inc(head_r) : head_r;
    app_cnt   = ring_full ? CNT_W'(WINDOW_DEPTH - 1) : cnt_r;
    wr_addr   = mem_addr(sidx_r, pos_wrap({1'b0, app_head} + (POS_W+1)'(app_cnt)));

    // Compare the port just read against the distinct ports found so far.
    cam_hit = 1'b0;
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      if ((CNT_W'(j) < k_r) && (cam_r[j] == rd_port)) begin
        cam_hit = 1'b1;
      end
    end

    thr       = udp_r ? udp_thr_r : tcp_thr_r;
    last_t    = last_a_r[sidx_r];
    cooling   = (last_t != '0) && (now_r > last_t) &&
                ((now_r - last_t) < TS_W'(cooldown_r));
    alert_now = (32'(k_r) >= 32'(thr)) && !cooling;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          sidx_nxt = in_sidx;
          now_nxt  = in_ts;
          port_nxt = port_sel;
          udp_nxt  = (in_proto == PROTO_UDP);
          head_nxt = head_a_r[in_sidx];
          cnt_nxt  = cnt_a_r[in_sidx];
          ovf_nxt  = 1'b0;
          if (pkt_ignore) begin
            // Ignored packet: all-zero result, state untouched.
            res_alert_nxt = 1'b0;
            res_udp_nxt   = 1'b0;
            res_dist_nxt  = '0;
            res_ovf_nxt   = 1'b0;
            state_nxt     = ST_RESULT;
          end else begin
            state_nxt = ST_EXPIRE;
          end
        end
      end
      ST_EXPIRE: begin
        if (cnt_r == '0) begin
          state_nxt = ST_APPEND;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_EXP_CHK;
        end
      end
      ST_EXP_CHK: begin
        if (expired) begin
          head_nxt  = pos_inc(head_r);
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_EXPIRE;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        wr_en     = 1'b1;
        head_nxt  = app_head;
        cnt_nxt   = app_cnt + CNT_W'(1);
        ovf_nxt   = ring_full;
        ir_nxt    = '0;
        pend_nxt  = 1'b0;
        k_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // Issue one read a cycle; check the previous one as it lands.
        if (ir_r < cnt_r) begin
          rd_en    = 1'b1;
          rd_addr  = mem_addr(sidx_r,
                              pos_wrap({1'b0, head_r} + (POS_W+1)'(ir_r)));
          ir_nxt   = ir_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && !cam_hit) begin
          cam_we = 1'b1;
          k_nxt  = k_r + CNT_W'(1);
        end
        if ((ir_r == cnt_r) && !pend_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        slot_we       = 1'b1;
        last_we       = alert_now;
        res_alert_nxt = alert_now;
        res_udp_nxt   = udp_r;
        res_dist_nxt  = (32'(k_r) > 127) ? 7'd127 : 7'(k_r);
        res_ovf_nxt   = ovf_r;
        state_nxt     = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-slot ring state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < FLOW_SLOTS; s++) begin
        head_a_r[s] <= '0;
        cnt_a_r[s]  <= '0;
        last_a_r[s] <= '0;
      end
    end else begin
      if (slot_we) begin
        head_a_r[sidx_r] <= head_r;
        cnt_a_r[sidx_r]  <= cnt_r;
      end
      if (last_we) begin
        last_a_r[sidx_r] <= now_r;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    sidx_r      <= sidx_nxt;
    now_r       <= now_nxt;
    port_r      <= port_nxt;
    udp_r       <= udp_nxt;
    head_r      <= head_nxt;
    cnt_r       <= cnt_nxt;
    ovf_r       <= ovf_nxt;
    ir_r        <= ir_nxt;
    k_r         <= k_nxt;
    res_alert_r <= res_alert_nxt;
    res_udp_r   <= res_udp_nxt;
    res_dist_r  <= res_dist_nxt;
    res_ovf_r   <= res_ovf_nxt;
    if (cam_we) begin
      cam_r[k_r[POS_W-1:0]] <= rd_port;
    end
    if (out_load) begin
      out_alert_r <= res_alert_r;
      out_udp_r   <= res_udp_r;
      out_dist_r  <= res_dist_r;
      out_ovf_r   <= res_ovf_r;
    end
  end

  // Event memory, one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      event_mem[wr_addr] <= {now_r, port_r};
    end
    if (rd_en) begin
      rd_data_r <= event_mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_udp_r;
  assign out_tdata  = {7'd0, out_ovf_r, out_dist_r, out_alert_r};

endmodule

`default_nettype wire

>>> src/pswd_checker.sv
// ----------------------------------------------------------------------------
// Port scan window detector checker
// Port-level checks bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "port_scan_window_detector_unit_assert.svh"

module pswd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [pswd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                            out_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready
);
  import pswd_pkg::*;

  // A stalled result holds.
  `PSWD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // One packet in work at a time: busy right after a transaction.
  `PSWD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // An alert always comes with at least the newly added port in the window.
  `PSWD_ASSERT_IMPLY(a_alert_has_ports, clk, rst_n, out_tvalid && out_tdata[0], out_tdata[7:1] != 7'd0)

  // The distinct count never exceeds the ring depth.
  `PSWD_ASSERT_IMPLY(a_dist_bound, clk, rst_n, out_tvalid, 32'(out_tdata[7:1]) <= WINDOW_DEPTH)

endmodule

bind port_scan_window_detector_unit pswd_checker u_pswd_checker (.*);

`default_nettype wire
